/* rtl/spq_pkg.sv */
// Package for the sorted priority queue: sizing constants, codes and the
// control struct shared by the cell chain and the top level. No dependencies.
`default_nettype none

package spq_pkg;

  // Number of entries in the cell chain
  localparam int unsigned CAPACITY = 16;
  // Width of the fill count, wide enough to hold CAPACITY itself
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  // Widths of the payload fields
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned COUNT_W  = 5;

  // Operation codes carried by the mode field
  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Per-transfer control broadcast to every cell
  typedef struct packed {
    logic insert_en;
    logic remove_en;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* rtl/spq_cell.sv */
// One cell of the sorted chain: holds one stored value and moves it to or
// from its neighbors on insert and remove. Depends on spq_pkg.
`default_nettype none

module spq_cell (
  input  wire logic                             clk,
  input  wire spq_pkg::cell_ctl_t               ctl,
  input  wire logic signed [spq_pkg::VAL_W-1:0] ins_value,
  input  wire logic                             occupied,
  input  wire logic                             left_keep,
  input  wire logic signed [spq_pkg::VAL_W-1:0] left_value,
  input  wire logic signed [spq_pkg::VAL_W-1:0] right_value,
  output logic signed [spq_pkg::VAL_W-1:0]      value,
  output logic                                  keep,
  output logic signed [spq_pkg::VAL_W-1:0]      value_next
);

  // Stored entry stays put when it is not above the incoming value;
  // equal values stay ahead so ties leave in arrival order
  assign keep = occupied && (value <= ins_value);

  // Insert: keep, take the new value at the boundary, or shift from the left.
  // Remove: shift from the right.
  always_comb begin
    value_next = value;
    if (ctl.insert_en) begin
      if (!keep) begin
        value_next = left_keep ? ins_value : left_value;
      end
    end else if (ctl.remove_en) begin
      value_next = right_value;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

/* rtl/sorted_priority_queue.sv */
// Sorted min priority queue: a chain of CAPACITY cells kept in ascending order.
// Latency: the result of an item is presented the cycle after its transfer.
// Throughput: one item per cycle while the output register is not stalled; each cell
// compares against the new value and registers its shift, and the output register frees the input side.
// Reset: clears the fill count and the output valid; cell contents are left as is.
// Depends on spq_pkg and spq_cell.
`default_nettype none

module sorted_priority_queue (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic                             mode,
  input  wire logic signed [spq_pkg::VAL_W-1:0] value,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [spq_pkg::VAL_W-1:0]      head_value,
  output logic [spq_pkg::COUNT_W-1:0]           count,
  output logic                                  empty_res,
  output logic [1:0]                            status
);

  localparam int unsigned N = spq_pkg::CAPACITY;

  logic                           in_xfer;
  logic [spq_pkg::CNT_W-1:0]      fill;
  logic [spq_pkg::CNT_W-1:0]      fill_next;
  logic                           is_full;
  logic                           is_empty;
  spq_pkg::status_t               status_next;
  spq_pkg::cell_ctl_t             ctl;
  logic [N-1:0]                   occupied;
  logic [N-1:0]                   keep;
  logic signed [spq_pkg::VAL_W-1:0] cell_value [N];
  logic signed [spq_pkg::VAL_W-1:0] cell_next  [N];

  // Input side is free whenever the output register is empty or draining
  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  assign is_full  = (fill == spq_pkg::CNT_W'(N));
  assign is_empty = (fill == '0);

  // Operation decode and error checks
  always_comb begin
    ctl         = '0;
    status_next = spq_pkg::ST_OK;
    fill_next   = fill;
    if (in_xfer) begin
      unique case (spq_pkg::mode_t'(mode))
        spq_pkg::MODE_INSERT: begin
          if (is_full) begin
            status_next = spq_pkg::ST_FULL;
          end else begin
            ctl.insert_en = 1'b1;
            fill_next     = fill + spq_pkg::CNT_W'(1);
          end
        end
        spq_pkg::MODE_REMOVE: begin
          if (is_empty) begin
            status_next = spq_pkg::ST_EMPTY;
          end else begin
            ctl.remove_en = 1'b1;
            fill_next     = fill - spq_pkg::CNT_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Cell chain
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                             l_keep;
    logic signed [spq_pkg::VAL_W-1:0] l_value;
    logic signed [spq_pkg::VAL_W-1:0] r_value;

    assign occupied[i] = (fill > spq_pkg::CNT_W'(i));

    if (i == 0) begin : g_first
      assign l_keep  = 1'b1;
      assign l_value = '0;
    end else begin : g_mid
      assign l_keep  = keep[i-1];
      assign l_value = cell_value[i-1];
    end

    if (i == N - 1) begin : g_last
      assign r_value = cell_value[i];
    end else begin : g_inner
      assign r_value = cell_value[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .ins_value   (value),
      .occupied    (occupied[i]),
      .left_keep   (l_keep),
      .left_value  (l_value),
      .right_value (r_value),
      .value       (cell_value[i]),
      .keep        (keep[i]),
      .value_next  (cell_next[i])
    );
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      head_value <= (fill_next != '0) ? cell_next[0] : '0;
      count      <= spq_pkg::COUNT_W'(fill_next);
      empty_res  <= (fill_next == '0);
      status     <= status_next;
    end
  end

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= spq_pkg::CNT_W'(N))
    else $error("fill count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (mode == spq_pkg::MODE_INSERT) && is_full |=>
      (status == spq_pkg::ST_FULL) && $stable(fill))
    else $error("insert into full store not flagged");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (empty_res == (count == '0)))
    else $error("empty flag disagrees with count");

  a_order_head: assert property (@(posedge clk) disable iff (rst)
    (fill >= spq_pkg::CNT_W'(2)) |-> (cell_value[0] <= cell_value[1]))
    else $error("head entry out of order");

endmodule

`default_nettype wire

/* dv/testbench.sv */
// Self-checking bench for sorted_priority_queue: a directed table, then random
// insert/remove traffic checked against a shadow sorted list. Needs spq_pkg.
`default_nettype none

module testbench;
  import spq_pkg::*;

  localparam int RANDOM_N    = 1400;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 8;

  localparam logic signed [VAL_W-1:0] V_MAX = 32'sh7fffffff;
  localparam logic signed [VAL_W-1:0] V_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [VAL_W-1:0] head;
    logic [COUNT_W-1:0]      cnt;
    logic                    empty;
    status_t                 st;
  } queue_report_t;

  typedef struct packed {
    mode_t                   op;
    logic signed [VAL_W-1:0] val;
    logic                    typed;
    queue_report_t           report;
  } stim_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    mode = MODE_INSERT;
  logic signed [VAL_W-1:0] value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b1;
  logic signed [VAL_W-1:0] head_value;
  logic [COUNT_W-1:0]      count;
  logic                    empty_res;
  logic [1:0]              status;

  // Shadow of the store and the reports it owes
  logic signed [VAL_W-1:0] shadow_list[$];
  queue_report_t           awaited_reports[$];

  stim_row_t     directed_rows[32];
  int            directed_n = 0;
  int            total_items;
  int            n_loaded = 0;
  int            n_sent = 0;
  int            n_errors = 0;
  int            cycle_cnt = 0;
  logic          cur_typed = 1'b0;
  queue_report_t cur_report;
  int            burst_left = 4;
  int            gap_left = 0;
  int            seg_left = 0;
  int            insert_pct = 50;
  int            stall_mode = 0;
  int            stall_left = 0;
  logic [7:0]    stall_pat = 8'b1011_0010;

  sorted_priority_queue u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head_value(head_value),
    .count     (count),
    .empty_res (empty_res),
    .status    (status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one operation to the shadow list and return the report it yields
  function automatic queue_report_t shadow_apply(mode_t op, logic signed [VAL_W-1:0] v);
    queue_report_t r;
    int pos;
    r.st = ST_OK;
    pos = 0;
    if (op == MODE_INSERT) begin
      if (shadow_list.size() >= CAPACITY) begin
        r.st = ST_FULL;
      end else begin
        // equal values stay ahead of the newcomer
        while (pos < shadow_list.size() && shadow_list[pos] <= v) pos++;
        shadow_list.insert(pos, v);
      end
    end else begin
      if (shadow_list.size() == 0) r.st = ST_EMPTY;
      else shadow_list.delete(0);
    end
    r.head  = (shadow_list.size() != 0) ? shadow_list[0] : '0;
    r.cnt   = COUNT_W'(shadow_list.size());
    r.empty = (shadow_list.size() == 0);
    return r;
  endfunction

  task automatic add_row(mode_t op, logic signed [VAL_W-1:0] v, logic typed,
                         logic signed [VAL_W-1:0] head, int cnt, logic empty,
                         status_t st);
    directed_rows[directed_n] = '{op, v, typed, '{head, COUNT_W'(cnt), empty, st}};
    directed_n++;
  endtask

  // Random value: mostly full-width, some tight range for ties, some extremes
  function automatic logic signed [VAL_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return $urandom;
    if (sel < 85) return VAL_W'($signed($urandom_range(0, 6)) - 3);
    case ($urandom_range(0, 6))
      0: return V_MIN;
      1: return V_MIN + 1;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return V_MAX - 1;
      default: return V_MAX;
    endcase
  endfunction

  // Put the next item on the input ports
  task automatic load_next();
    mode_t op;
    if (n_loaded < directed_n) begin
      mode       <= directed_rows[n_loaded].op;
      value      <= directed_rows[n_loaded].val;
      cur_typed  = directed_rows[n_loaded].typed;
      cur_report = directed_rows[n_loaded].report;
    end else begin
      // insert bias changes per segment so the queue swings between full and empty
      if (seg_left == 0) begin
        seg_left = $urandom_range(16, 48);
        case ($urandom_range(0, 2))
          0: insert_pct = 15;
          1: insert_pct = 50;
          default: insert_pct = 85;
        endcase
      end
      seg_left--;
      op = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
      mode      <= op;
      value     <= pick_value();
      cur_typed = 1'b0;
    end
    n_loaded++;
  endtask

  initial begin
    // Extremes, empty removal and ordering through a short fill and drain
    add_row(MODE_REMOVE, 0, 1'b1, 0, 0, 1'b1, ST_EMPTY);
    add_row(MODE_INSERT, V_MAX, 1'b1, V_MAX, 1, 1'b0, ST_OK);
    add_row(MODE_INSERT, V_MIN, 1'b1, V_MIN, 2, 1'b0, ST_OK);
    add_row(MODE_INSERT, 0, 1'b1, V_MIN, 3, 1'b0, ST_OK);
    add_row(MODE_REMOVE, 0, 1'b1, 0, 2, 1'b0, ST_OK);
    add_row(MODE_REMOVE, 0, 1'b1, V_MAX, 1, 1'b0, ST_OK);
    add_row(MODE_REMOVE, 0, 1'b1, 0, 0, 1'b1, ST_OK);
    // removal value is don't-care
    add_row(MODE_REMOVE, -1, 1'b1, 0, 0, 1'b1, ST_EMPTY);
    // Fill to capacity with duplicates and extremes
    add_row(MODE_INSERT, 7, 1'b0, 0, 0, 1'b0, ST_OK);
    add_row(MODE_INSERT, -7, 1'b0, 0, 0, 1'b0, ST_OK);
    add_row(MODE_INSERT, 7, 1'b0, 0, 0, 1'b0, ST_OK);
    add_row(MODE_INSERT, V_MAX, 1'b0, 0, 0, 1'b0, ST_OK);
    add_row(MODE_INSERT, V_MIN, 1'b0, 0, 0, 1'b0, ST_OK);
    add_row(MODE_INSERT, 0, 1'b0, 0, 0, 1'b0, ST_OK);
    add_row(MODE_INSERT, -1, 1'b0, 0, 0, 1'b0, ST_OK);
    add_row(MODE_INSERT, 1, 1'b0, 0, 0, 1'b0, ST_OK);
    add_row(MODE_INSERT, 7, 1'b0, 0, 0, 1'b0, ST_OK);
    add_row(MODE_INSERT, V_MIN, 1'b0, 0, 0, 1'b0, ST_OK);
    add_row(MODE_INSERT, V_MAX, 1'b0, 0, 0, 1'b0, ST_OK);
    add_row(MODE_INSERT, V_MIN + 1, 1'b0, 0, 0, 1'b0, ST_OK);
    add_row(MODE_INSERT, V_MAX - 1, 1'b0, 0, 0, 1'b0, ST_OK);
    add_row(MODE_INSERT, 3, 1'b0, 0, 0, 1'b0, ST_OK);
    add_row(MODE_INSERT, -7, 1'b0, 0, 0, 1'b0, ST_OK);
    add_row(MODE_INSERT, 0, 1'b0, 0, 0, 1'b0, ST_OK);
    // Full: insert dropped; then a removal exposes the second minimum
    add_row(MODE_INSERT, 5, 1'b1, V_MIN, 16, 1'b0, ST_FULL);
    add_row(MODE_REMOVE, 0, 1'b1, V_MIN, 15, 1'b0, ST_OK);
    total_items = directed_n + RANDOM_N;
  end

  // Reset, then wait for the last report and a short quiet period
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (n_sent < total_items || awaited_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_errors == 0 && awaited_reports.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("%0t: timeout with %0d reports outstanding", $time, awaited_reports.size());
    $display("TB_ERROR");
    $finish;
  end

  // Check reports, record input transfers, then drive both channels
  always @(posedge clk) begin
    queue_report_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (awaited_reports.size() == 0) begin
        n_errors++;
        $display("%0t: report exp none got head=%0d count=%0d", $time, head_value, count);
      end else begin
        exp_r = awaited_reports[0];
        awaited_reports.delete(0);
        if (head_value !== exp_r.head) begin
          n_errors++;
          $display("%0t: head_value exp %0d got %0d", $time, exp_r.head, head_value);
        end
        if (count !== exp_r.cnt) begin
          n_errors++;
          $display("%0t: count exp %0d got %0d", $time, exp_r.cnt, count);
        end
        if (empty_res !== exp_r.empty) begin
          n_errors++;
          $display("%0t: empty_res exp %0b got %0b", $time, exp_r.empty, empty_res);
        end
        if (status !== exp_r.st) begin
          n_errors++;
          $display("%0t: status exp %0d got %0d", $time, exp_r.st, status);
        end
      end
    end

    if (!rst && in_valid && in_ready) begin
      exp_r = shadow_apply(mode_t'(mode), value);
      // typed rows stand in for the shadow's report
      awaited_reports.insert(awaited_reports.size(), cur_typed ? cur_report : exp_r);
      n_sent++;
    end

    // Sender: bursts of back-to-back items separated by random gaps
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (n_loaded >= total_items) begin
        in_valid <= 1'b0;
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else begin
        in_valid <= 1'b1;
        load_next();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end

    // Receiver: stall pattern switches at random between modes
    if (stall_left == 0) begin
      stall_left = $urandom_range(50, 300);
      stall_mode = $urandom_range(0, 3);
      stall_pat  = 8'($urandom_range(1, 255));
    end
    stall_left--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) < 7);
      2: begin
        out_ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[7:1]};
      end
      default: out_ready <= ($urandom_range(0, 9) < 3);
    endcase
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
dv/testbench.sv
